### design/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared sizes and constants of the deficit round robin pick core.
// ----------------------------------------------------------------------------
package dfr_pkg;

   localparam int NUM_QUEUES      = 4;
   localparam int DEFICIT_BITS    = 24;
   localparam int QIDX_BITS       = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

   localparam int MASK_BITS       = 4;
   localparam int HEAD_LEN_BITS   = 16;
   localparam int QUANTUM_BITS    = 16;
   localparam int GRANT_Q_BITS    = 2;

   localparam int REQ_FIELD_BITS  = MASK_BITS + 4 * HEAD_LEN_BITS;
   localparam int REQ_DATA_BITS   = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS  = 1 + GRANT_Q_BITS + 1;
   localparam int RSP_DATA_BITS   = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [QUANTUM_BITS-1:0] QUANTUM_RESET = QUANTUM_BITS'(1500);
   localparam logic [DEFICIT_BITS-1:0] DEFICIT_RESET =
      {{(DEFICIT_BITS-QUANTUM_BITS){1'b0}}, QUANTUM_RESET};
   localparam logic [DEFICIT_BITS-1:0] DEFICIT_MAX = {DEFICIT_BITS{1'b1}};

   typedef logic [DEFICIT_BITS-1:0]  deficit_type;
   typedef logic [HEAD_LEN_BITS-1:0] head_len_type;

endpackage

### design/dfr_ram.sv
// ----------------------------------------------------------------------------
// dfr_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/deficit_round_robin_pick_core.sv
// ----------------------------------------------------------------------------
// deficit_round_robin_pick_core
// Deficit round robin pick: one grant decision per request beat.
// ----------------------------------------------------------------------------
// The deficit counters live in a small RAM and are walked one queue per cycle
// through its single read port. A request whose first scan finds an eligible
// queue q stops the scan at q; with no non-empty queue it scans every queue;
// a request that ends a round runs one scan, then a refill-and-rescan pass
// that writes every counter back. The result beat is registered; a new request
// is taken once the previous result has been delivered. After reset all
// counters read as 1500 until first written.
module deficit_round_robin_pick_core
   import dfr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // req_tdata: nonempty_mask[3:0], head_len_q0..head_len_q3 (16 bits each)
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // rsp_tdata: granted[0], grant_queue[2:1], round_refilled[3]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_wr_en,
   input  logic [QUANTUM_BITS-1:0]  csr_wr_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_RESCAN = 2'd2;

   localparam logic [QIDX_BITS-1:0] LAST_Q = QIDX_BITS'(NUM_QUEUES - 1);

   logic [1:0]              state_ff, state_in;
   logic [QIDX_BITS-1:0]    idx_ff, idx_in;
   logic [NUM_QUEUES-1:0]   mask_ff, mask_in;
   head_len_type            len_ff [NUM_QUEUES];
   head_len_type            len_in [NUM_QUEUES];
   logic [NUM_QUEUES-1:0]   valid_ff, valid_in;
   logic                    hit_ff, hit_in;
   logic [QIDX_BITS-1:0]    hit_q_ff, hit_q_in;
   logic [QUANTUM_BITS-1:0] quantum_ff, quantum_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_granted_ff, rsp_granted_in;
   logic [GRANT_Q_BITS-1:0] rsp_queue_ff, rsp_queue_in;
   logic                    rsp_refill_ff, rsp_refill_in;

   logic                    wr_en;
   deficit_type             wr_data;
   deficit_type             rd_data;
   deficit_type             cur_def;
   deficit_type             cur_len;
   deficit_type             sat_def;
   logic [DEFICIT_BITS:0]   sum_w;
   logic                    req_accept;
   logic                    hit_now;

   dfr_ram #(
      .WIDTH (DEFICIT_BITS),
      .DEPTH (NUM_QUEUES)
   ) u_deficit_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_accept = req_tvalid && req_tready;

   // never-written entries hold the reset quantum
   assign cur_def = valid_ff[idx_ff] ? rd_data : DEFICIT_RESET;
   assign cur_len = {{(DEFICIT_BITS-HEAD_LEN_BITS){1'b0}}, len_ff[idx_ff]};
   assign sum_w   = {1'b0, cur_def} + {{(DEFICIT_BITS+1-QUANTUM_BITS){1'b0}}, quantum_ff};
   assign sat_def = sum_w[DEFICIT_BITS] ? DEFICIT_MAX : sum_w[DEFICIT_BITS-1:0];
   assign hit_now = !hit_ff && mask_ff[idx_ff] && (sat_def != '0) && (sat_def >= cur_len);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      mask_in        = mask_ff;
      len_in         = len_ff;
      valid_in       = valid_ff;
      hit_in         = hit_ff;
      hit_q_in       = hit_q_ff;
      quantum_in     = csr_wr_en ? csr_wr_data : quantum_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_granted_in = rsp_granted_ff;
      rsp_queue_in   = rsp_queue_ff;
      rsp_refill_in  = rsp_refill_ff;
      wr_en          = 1'b0;
      wr_data        = sat_def;

      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_accept) begin
               state_in = ST_SCAN;
               hit_in   = 1'b0;
               hit_q_in = '0;
               mask_in  = req_tdata[NUM_QUEUES-1:0];
               for (int q = 0; q < NUM_QUEUES; q++) begin
                  len_in[q] = req_tdata[MASK_BITS + q*HEAD_LEN_BITS +: HEAD_LEN_BITS];
               end
            end
         end
         ST_SCAN: begin
            if (mask_ff[idx_ff] && (cur_def >= cur_len)) begin
               wr_en          = 1'b1;
               wr_data        = cur_def - cur_len;
               state_in       = ST_IDLE;
               idx_in         = '0;
               rsp_valid_in   = 1'b1;
               rsp_granted_in = 1'b1;
               rsp_queue_in   = GRANT_Q_BITS'(idx_ff);
               rsp_refill_in  = 1'b0;
            end else if (idx_ff == LAST_Q) begin
               idx_in = '0;
               if (|mask_ff) begin
                  state_in = ST_RESCAN;
               end else begin
                  state_in       = ST_IDLE;
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = 1'b0;
                  rsp_queue_in   = '0;
                  rsp_refill_in  = 1'b0;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_RESCAN: begin
            // refill every counter, grant the first eligible queue once
            wr_en = 1'b1;
            if (hit_now) begin
               wr_data  = sat_def - cur_len;
               hit_in   = 1'b1;
               hit_q_in = idx_ff;
            end
            if (idx_ff == LAST_Q) begin
               state_in       = ST_IDLE;
               idx_in         = '0;
               rsp_valid_in   = 1'b1;
               rsp_granted_in = hit_ff || hit_now;
               rsp_queue_in   = GRANT_Q_BITS'(hit_now ? idx_ff : hit_q_ff);
               rsp_refill_in  = 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            idx_in   = '0;
         end
      endcase

      if (wr_en) begin
         valid_in[idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         valid_ff     <= '0;
         hit_ff       <= 1'b0;
         quantum_ff   <= QUANTUM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         valid_ff     <= valid_in;
         hit_ff       <= hit_in;
         quantum_ff   <= quantum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff        <= mask_in;
      len_ff         <= len_in;
      hit_q_ff       <= hit_q_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_queue_ff   <= rsp_queue_in;
      rsp_refill_ff  <= rsp_refill_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-RSP_FIELD_BITS){1'b0}},
                        rsp_refill_ff, rsp_queue_ff, rsp_granted_ff};

endmodule

### dv/deficit_round_robin_pick_core_test.sv
// ----------------------------------------------------------------------------
// deficit_round_robin_pick_core_test
// Drives pick requests into the deficit round robin core under random
// source gaps and sink stalls. Keeps its own copy of the per-queue deficits
// and the quantum, predicts every grant decision, and compares each result
// beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module deficit_round_robin_pick_core_test;
   import dfr_pkg::*;

   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 2 * NUM_QUEUES + 4;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int MAX_REPORTS    = 10;

   // request beat: mask in the low bits, then head lengths of queue 0 upward
   typedef struct packed {
      head_len_type [NUM_QUEUES-1:0] len;
      logic [MASK_BITS-1:0]          mask;
   } req_beat_type;

   typedef struct packed {
      logic                    refilled;
      logic [GRANT_Q_BITS-1:0] queue;
      logic                    granted;
   } pick_result_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_wr_en   = 1'b0;
   logic [QUANTUM_BITS-1:0]  csr_wr_data = '0;

   deficit_type               model_deficit [NUM_QUEUES];
   logic [QUANTUM_BITS-1:0]   model_quantum = QUANTUM_RESET;
   pick_result_type           expected_picks [$];

   int  mismatch_count = 0;
   int  burst_left     = 0;
   bit  steady_sender  = 1'b0;
   bit  hold_request   = 1'b0;

   deficit_round_robin_pick_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Scan for the first eligible queue; when none is and some queue is non-empty,
   // refill all deficits, then rescan once; a zero deficit never wins the rescan.
   function automatic pick_result_type predict_pick(req_beat_type beat);
      pick_result_type         res;
      logic [DEFICIT_BITS:0]   sum;
      res = '0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
         if (beat.mask[q] && model_deficit[q] >= beat.len[q]) begin
            model_deficit[q] = model_deficit[q] - beat.len[q];
            res.granted = 1'b1;
            res.queue   = GRANT_Q_BITS'(q);
            return res;
         end
      end
      if (beat.mask[NUM_QUEUES-1:0] == '0)
         return res;
      for (int q = 0; q < NUM_QUEUES; q++) begin
         sum = {1'b0, model_deficit[q]} + model_quantum;
         model_deficit[q] = (sum > DEFICIT_MAX) ? DEFICIT_MAX : sum[DEFICIT_BITS-1:0];
      end
      res.refilled = 1'b1;
      for (int q = 0; q < NUM_QUEUES; q++) begin
         if (beat.mask[q] && model_deficit[q] != '0 && model_deficit[q] >= beat.len[q]) begin
            model_deficit[q] = model_deficit[q] - beat.len[q];
            res.granted = 1'b1;
            res.queue   = GRANT_Q_BITS'(q);
            return res;
         end
      end
      return res;
   endfunction

   function automatic req_beat_type random_request();
      req_beat_type beat;
      int           pick;
      int           scale;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         beat.mask = '0;
      else if (pick < 4)
         beat.mask = MASK_BITS'(1 << $urandom_range(0, NUM_QUEUES - 1));
      else
         beat.mask = MASK_BITS'($urandom);
      scale = 2 * int'(model_quantum) + 16;
      if (scale > 65535)
         scale = 65535;
      for (int q = 0; q < NUM_QUEUES; q++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3: beat.len[q] = HEAD_LEN_BITS'($urandom_range(0, scale));
            4, 5:       beat.len[q] = HEAD_LEN_BITS'($urandom);
            6:          beat.len[q] = '0;
            7:          beat.len[q] = '1;
            default:    beat.len[q] =
                           HEAD_LEN_BITS'(model_quantum + $urandom_range(0, 8) - 4);
         endcase
      end
      return beat;
   endfunction

   // Offer one beat and hold it until taken; returns at the next falling edge.
   task automatic send_request(input req_beat_type beat);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0 || steady_sender) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tdata  = REQ_DATA_BITS'(beat);
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_picks.push_back(predict_pick(beat));
      @(negedge clock);
   endtask

   task automatic send_fields(input logic [MASK_BITS-1:0] mask, input head_len_type l0,
                              input head_len_type l1, input head_len_type l2,
                              input head_len_type l3);
      req_beat_type beat;
      beat.mask   = mask;
      beat.len[0] = l0;
      beat.len[1] = l1;
      beat.len[2] = l2;
      beat.len[3] = l3;
      send_request(beat);
   endtask

   task automatic wait_until_idle();
      req_tvalid = 1'b0;
      while (expected_picks.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_quantum(input logic [QUANTUM_BITS-1:0] value);
      wait_until_idle();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en     = 1'b0;
      model_quantum = value;
   endtask

   task automatic run_directed_picks();
      send_fields(4'b0000, '1, '1, '1, '1);
      // deficits must survive a quantum write untouched
      write_quantum('0);
      send_fields(4'b0001, 16'd1500, '0, '0, '0);
      send_fields(4'b0001, '0, '1, '1, '1);
      send_fields(4'b0001, 16'd1, '0, '0, '0);
      send_fields(4'b0010, '1, 16'd1500, '0, '0);
      write_quantum('1);
      send_fields(4'b1111, '1, '1, '1, '1);
      send_fields(4'b1110, '0, '1, 16'hAAAA, 16'h5555);
      send_fields(4'b1100, '0, '0, 16'h5555, 16'hAAAA);
      send_fields(4'b1000, '1, '1, '1, '1);
      send_fields(4'b0100, '0, '0, '1, '0);
      write_quantum(QUANTUM_RESET);
      send_fields(4'b1010, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_fields(4'b0101, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
      send_fields(4'b0000, '0, '0, '0, '0);
      send_fields(4'b1111, '0, '0, '0, '0);
   endtask

   task automatic run_random_traffic(input int count);
      logic [QUANTUM_BITS-1:0] setting;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0:       setting = QUANTUM_BITS'($urandom_range(1, 64));
            1:       setting = QUANTUM_BITS'($urandom);
            2:       setting = (phase < 4) ? '0 : '1;
            default: setting = QUANTUM_BITS'($urandom_range(1000, 9000));
         endcase
         write_quantum(setting);
         steady_sender = ($urandom_range(0, 3) == 0);
         repeat (count / 8) send_request(random_request());
      end
      steady_sender = 1'b0;
   endtask

   // Stall the sink long enough that the core backs up into its input.
   task automatic run_backpressure();
      wait_until_idle();
      hold_request  = 1'b1;
      steady_sender = 1'b1;
      repeat (40) send_request(random_request());
      steady_sender = 1'b0;
      wait_until_idle();
   endtask

   // Refill with the largest quantum until the untouched queues pin at max.
   task automatic run_deficit_saturation();
      write_quantum('1);
      repeat (300) send_fields(4'b0001, '1, '0, '0, '0);
      repeat (3) send_fields(4'b0010, '0, '1, '0, '0);
      send_fields(4'b1110, '0, '0, '0, '0);
      send_fields(4'b1000, '0, '0, '0, '1);
      wait_until_idle();
   endtask

   initial begin : receiver
      int mode;
      int mode_left;
      int tick;
      mode      = 0;
      mode_left = 0;
      tick      = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(32, 400);
         end
         mode_left--;
         tick++;
         case (mode)
            0:       rsp_tready = 1'b1;
            1:       rsp_tready = ($urandom_range(0, 3) != 0);
            default: rsp_tready = ((tick % 5) < 2);
         endcase
      end
   end

   always @(posedge clock) begin : check_pick
      pick_result_type got;
      pick_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RSP_FIELD_BITS-1:0];
         if (expected_picks.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result beat: granted=%0d queue=%0d refilled=%0d",
                        got.granted, got.queue, got.refilled);
         end else begin
            want = expected_picks.pop_front();
            if (got.granted !== want.granted || got.queue !== want.queue ||
                got.refilled !== want.refilled) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $write("pick mismatch: expected granted=%0d queue=%0d refilled=%0d, ",
                         want.granted, want.queue, want.refilled);
                  $display("got granted=%0d queue=%0d refilled=%0d",
                           got.granted, got.queue, got.refilled);
               end
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL deficit_round_robin_pick_core");
            $finish;
         end
      end
   end

   initial begin : main
      for (int q = 0; q < NUM_QUEUES; q++)
         model_deficit[q] = DEFICIT_RESET;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      run_directed_picks();
      run_random_traffic(800);
      run_backpressure();
      run_random_traffic(800);
      run_deficit_saturation();
      wait_until_idle();
      if (mismatch_count == 0 && expected_picks.size() == 0)
         $display("PASS deficit_round_robin_pick_core");
      else
         $display("FAIL deficit_round_robin_pick_core");
      $finish;
   end

endmodule
